/* hdl/priority_queue_extract_max_macros.svh */
// Assertion macros for the priority queue extract-max block.
// Used by the port checker; no other dependencies.
`ifndef PRIORITY_QUEUE_EXTRACT_MAX_MACROS_SVH
`define PRIORITY_QUEUE_EXTRACT_MAX_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define PQX_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PQX_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pqx_pkg.sv */
// Shared types and constants for the priority queue extract-max block.
// No dependencies; imported by every module of the block except pqx_ram.
`default_nettype none
package pqx_pkg;

  localparam int VALUE_BITS = 16;
  localparam int PRIO_BITS  = 8;
  localparam int COUNT_BITS = 5;
  localparam int CAP_BITS   = 5;
  localparam int DEPTH_DEF  = 16;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_EXTRACT = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [VALUE_BITS-1:0] value;
    logic [PRIO_BITS-1:0]  priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] out_value;
    logic [COUNT_BITS-1:0] count;
    logic                  is_empty;
    logic                  is_full;
  } rsp_t;

  typedef struct packed {
    logic    add_wr;
    logic    clear;
    logic    scan_init;
    logic    scan_rd;
    logic    shift_set;
    logic    shift_rd;
    logic    fill_dec;
    logic    respond;
    logic    take_value;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;
    logic shift_done;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/pqx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pqx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* hdl/pqx_dp.sv */
// Datapath: entry RAM, fill count, capacity register, scan and shift pointers.
// Depends on pqx_pkg and pqx_ram; driven by pqx_ctrl commands.
`default_nettype none
module pqx_dp #(
  parameter int DEPTH = 16
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  pqx_pkg::req_t                  req_i,
  input  pqx_pkg::cmd_t                  cmd_i,
  output pqx_pkg::sts_t                  sts_o,
  input  wire                            cfg_we_i,
  input  wire  [pqx_pkg::CAP_BITS-1:0]   cfg_wdata_i,
  output pqx_pkg::rsp_t                  rsp_o
);
  import pqx_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EW    = VALUE_BITS + PRIO_BITS;

  logic [CAP_BITS-1:0]   cap_q;
  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [AW-1:0]         cmp_idx_q;
  logic                  cmp_vld_q;
  logic [AW-1:0]         best_idx_q;
  logic [PRIO_BITS-1:0]  best_prio_q;
  logic [VALUE_BITS-1:0] best_val_q;
  logic [AW-1:0]         sh_addr_q;
  logic                  sh_vld_q;
  rsp_t                  rsp_q;

  logic [CNT_W-1:0]      eff_cap;
  logic                  full;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic                  ram_re;
  logic [EW-1:0]         ram_rdata;
  logic [PRIO_BITS-1:0]  rd_prio;
  logic [VALUE_BITS-1:0] rd_val;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign full = (fill_q >= eff_cap);

  assign sts_o.full       = full;
  assign sts_o.empty      = (fill_q == '0);
  assign sts_o.scan_last  = (CNT_W'(idx_q + CNT_W'(1)) == fill_q);
  assign sts_o.shift_done = (idx_q >= fill_q);

  assign ram_re    = cmd_i.scan_rd | cmd_i.shift_rd;
  assign ram_we    = cmd_i.add_wr | sh_vld_q;
  assign ram_waddr = cmd_i.add_wr ? fill_q[AW-1:0] : sh_addr_q;
  assign ram_wdata = cmd_i.add_wr ? {req_i.priority_req, req_i.value} : ram_rdata;
  assign rd_prio   = ram_rdata[EW-1:VALUE_BITS];
  assign rd_val    = ram_rdata[VALUE_BITS-1:0];

  pqx_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.add_wr) begin
      fill_d = CNT_W'(fill_q + CNT_W'(1));
    end else if (cmd_i.fill_dec) begin
      fill_d = CNT_W'(fill_q - CNT_W'(1));
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.scan_init) begin
      idx_d = '0;
    end else if (cmd_i.shift_set) begin
      idx_d = CNT_W'(CNT_W'(best_idx_q) + CNT_W'(1));
    end else if (ram_re) begin
      idx_d = CNT_W'(idx_q + CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      fill_q    <= '0;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      sh_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmd_i.scan_rd;
      sh_vld_q  <= cmd_i.shift_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q[AW-1:0];
    sh_addr_q <= AW'(idx_q[AW-1:0] - AW'(1));
    if (cmp_vld_q && (cmp_idx_q == '0 || rd_prio > best_prio_q)) begin
      best_idx_q  <= cmp_idx_q;
      best_prio_q <= rd_prio;
      best_val_q  <= rd_val;
    end
    if (cmd_i.respond) begin
      rsp_q.status    <= cmd_i.status;
      rsp_q.out_value <= cmd_i.take_value ? best_val_q : '0;
      rsp_q.count     <= COUNT_BITS'(fill_q);
      rsp_q.is_empty  <= (fill_q == '0);
      rsp_q.is_full   <= full;
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

/* hdl/pqx_ctrl.sv */
// Controller: one-hot sequencer for add, extract (scan then shift) and clear.
// Depends on pqx_pkg; commands pqx_dp.
`default_nettype none
module pqx_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  output logic           busy,
  input  wire  [1:0]     func_i,
  input  pqx_pkg::sts_t  sts_i,
  output pqx_pkg::cmd_t  cmd_o,
  output logic           done_o
);
  import pqx_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SCAN      = 6'b000010,
    S_SCAN_WAIT = 6'b000100,
    S_SHIFT_SET = 6'b001000,
    S_SHIFT     = 6'b010000,
    S_RESP      = 6'b100000
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    take_q, take_d;
  logic    done_q;

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    take_d  = take_q;
    cmd_o   = '0;
    cmd_o.status     = st_q;
    cmd_o.take_value = take_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          st_d    = ST_OK;
          take_d  = 1'b0;
          state_d = S_RESP;
          case (func_e'(func_i))
            FUNC_ADD: begin
              if (sts_i.full) begin
                st_d = ST_FULL;
              end else begin
                cmd_o.add_wr = 1'b1;
              end
            end
            FUNC_EXTRACT: begin
              if (sts_i.empty) begin
                st_d = ST_EMPTY;
              end else begin
                cmd_o.scan_init = 1'b1;
                take_d          = 1'b1;
                state_d         = S_SCAN;
              end
            end
            FUNC_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_d = S_SHIFT_SET;
      end
      S_SHIFT_SET: begin
        cmd_o.shift_set = 1'b1;
        state_d         = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          cmd_o.fill_dec = 1'b1;
          state_d        = S_RESP;
        end else begin
          cmd_o.shift_rd = 1'b1;
        end
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
      take_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      take_q  <= take_d;
      done_q  <= (state_q == S_RESP);
    end
  end

endmodule
`default_nettype wire

/* hdl/priority_queue_extract_max.sv */
// Channel  | Direction | Handshake
// request  | in        | start high while busy low; no new beat while busy
// result   | out       | done_o strobe, one cycle, no back-pressure
// capacity | in        | cfg_we_i high writes cfg_wdata_i at the edge
//
// Add, clear and no-op go from the accepting edge to S_RESP; done_o is registered from S_RESP.
// Extract steps through S_SCAN, S_SCAN_WAIT, S_SHIFT_SET, S_SHIFT and S_RESP in turn,
// with one RAM read per cycle for the scan and one per shifted entry.
// Reset is asynchronous, active low; the queue comes up empty, capacity 16.
// busy stays high from the accepting edge until the result strobe.
// Top level: priority queue with linear extract-max; depends on pqx_pkg, pqx_ctrl, pqx_dp.
`default_nettype none
module priority_queue_extract_max #(
  parameter int DEPTH = pqx_pkg::DEPTH_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  pqx_pkg::req_t                req_i,
  output logic                         done_o,
  output pqx_pkg::rsp_t                rsp_o,
  input  wire                          cfg_we_i,
  input  wire  [pqx_pkg::CAP_BITS-1:0] cfg_wdata_i
);
  import pqx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pqx_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .func_i (req_i.func),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  pqx_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire

/* hdl/pqx_checker.sv */
// Port-level checker for the priority queue extract-max block, bound to the top.
// Depends on pqx_pkg and priority_queue_extract_max_macros.svh.
`default_nettype none
`include "priority_queue_extract_max_macros.svh"
module pqx_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           start,
  input wire           busy,
  input wire           done_o,
  input pqx_pkg::rsp_t rsp_o
);
  import pqx_pkg::*;

  `PQX_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted beat did not raise busy")
  `PQX_ASSERT_NXT(a_strobe_single, clk_i, rst_ni, done_o, !done_o, "result strobe held for two cycles")
  `PQX_ASSERT_IMP(a_empty_flag, clk_i, rst_ni, done_o, rsp_o.is_empty == (rsp_o.count == '0), "empty flag disagrees with count")
  `PQX_ASSERT_IMP(a_full_drop, clk_i, rst_ni, done_o && rsp_o.status == ST_FULL, rsp_o.is_full && rsp_o.out_value == '0, "dropped add without full flag")
  `PQX_ASSERT_IMP(a_empty_extract, clk_i, rst_ni, done_o && rsp_o.status == ST_EMPTY, rsp_o.is_empty && rsp_o.out_value == '0, "empty extract with entries held")

endmodule

bind priority_queue_extract_max pqx_checker u_pqx_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
`default_nettype wire
